FILE: rtl/smi_pkg.sv
// Shared widths, item types and cell types for the symmetric 3x3 inverse unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package smi_pkg;

    localparam int W      = 32;
    localparam int F      = 24;
    localparam int LANES  = 6;
    localparam int CP_W   = 2 * W + 1;
    localparam int DET_W  = 3 * W + 1;
    localparam int DEN_W  = 3 * W + 1;
    localparam int NUM_A  = 2 * W + 2 * F + 1;
    localparam int NUM_W  = ((NUM_A > DET_W) ? NUM_A : DET_W) + 1;
    localparam int HI_W   = NUM_W - W;
    localparam int XW     = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int FRONT  = 7;

    typedef struct packed {
        logic signed [W-1:0] g_xx;
        logic signed [W-1:0] g_xy;
        logic signed [W-1:0] g_xz;
        logic signed [W-1:0] g_yy;
        logic signed [W-1:0] g_yz;
        logic signed [W-1:0] g_zz;
    } t_in_item;

    typedef struct packed {
        logic signed [W-1:0] inv_xx;
        logic signed [W-1:0] inv_xy;
        logic signed [W-1:0] inv_xz;
        logic signed [W-1:0] inv_yy;
        logic signed [W-1:0] inv_yz;
        logic signed [W-1:0] inv_zz;
        logic                bad_determinant;
        logic                saturated;
    } t_out_item;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [W-1:0]     low;
        logic [W-1:0]     q;
        logic             neg;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        logic                  valid;
        logic                  bad;
        logic [DEN_W-1:0]      den;
        t_lane [LANES-1:0]     lane;
    } t_cell;

endpackage
`default_nettype wire

FILE: rtl/smi_front.sv
// Front pipeline: products, cofactors, determinant and divider set-up.
// Depends on smi_pkg; feeds the first divider cell.
`default_nettype none
module smi_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  wire                    i_valid,
    input  wire smi_pkg::t_in_item i_item,
    output smi_pkg::t_cell         o_cell
);

    logic [smi_pkg::FRONT-2:0] r_v;

    logic signed [2*smi_pkg::W-1:0]   r_p [12];
    logic signed [smi_pkg::W-1:0]     r_x1 [3];
    logic signed [smi_pkg::W-1:0]     r_x2 [3];
    logic signed [smi_pkg::CP_W-1:0]  r_c2 [6];
    logic signed [smi_pkg::CP_W-1:0]  r_c3 [6];
    logic signed [smi_pkg::CP_W-1:0]  r_c4 [6];
    logic signed [smi_pkg::CP_W-1:0]  r_c5 [6];
    logic signed [smi_pkg::CP_W:0]    r_pl [3];
    logic signed [smi_pkg::CP_W:0]    r_ph [3];
    logic signed [smi_pkg::DET_W-1:0] r_t [3];
    logic signed [smi_pkg::DET_W-1:0] r_det;
    logic [smi_pkg::NUM_W-1:0]        r_num [6];
    logic [smi_pkg::LANES-1:0]        r_neg;
    logic [smi_pkg::DEN_W-1:0]        r_den;
    logic                             r_bad;
    smi_pkg::t_cell                   r_out;
    logic [2*smi_pkg::W-1:0]          c5_mag [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            c5_mag[k] = r_c5[k][smi_pkg::CP_W-1]
                        ? (2 * smi_pkg::W)'(0) - r_c5[k][2*smi_pkg::W-1:0]
                        : r_c5[k][2*smi_pkg::W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_v         <= {r_v[smi_pkg::FRONT-3:0], i_valid};
            r_out.valid <= r_v[smi_pkg::FRONT-2];
            r_p[0]  <= i_item.g_yy * i_item.g_zz;
            r_p[1]  <= i_item.g_yz * i_item.g_yz;
            r_p[2]  <= i_item.g_xz * i_item.g_yz;
            r_p[3]  <= i_item.g_xy * i_item.g_zz;
            r_p[4]  <= i_item.g_xy * i_item.g_yz;
            r_p[5]  <= i_item.g_yy * i_item.g_xz;
            r_p[6]  <= i_item.g_xx * i_item.g_zz;
            r_p[7]  <= i_item.g_xz * i_item.g_xz;
            r_p[8]  <= i_item.g_xy * i_item.g_xz;
            r_p[9]  <= i_item.g_xx * i_item.g_yz;
            r_p[10] <= i_item.g_xx * i_item.g_yy;
            r_p[11] <= i_item.g_xy * i_item.g_xy;
            r_x1[0] <= i_item.g_xx;
            r_x1[1] <= i_item.g_xy;
            r_x1[2] <= i_item.g_xz;
            for (int k = 0; k < 6; k++) begin
                r_c2[k] <= smi_pkg::CP_W'(r_p[2*k]) - smi_pkg::CP_W'(r_p[2*k+1]);
            end
            r_x2 <= r_x1;
            for (int j = 0; j < 3; j++) begin
                r_pl[j] <= r_x2[j] * $signed({1'b0, r_c2[j][smi_pkg::W-1:0]});
                r_ph[j] <= r_x2[j] * $signed(r_c2[j][smi_pkg::CP_W-1:smi_pkg::W]);
            end
            r_c3 <= r_c2;
            for (int j = 0; j < 3; j++) begin
                r_t[j] <= (smi_pkg::DET_W'(r_ph[j]) <<< smi_pkg::W)
                          + smi_pkg::DET_W'(r_pl[j]);
            end
            r_c4 <= r_c3;
            r_det <= r_t[0] + r_t[1] + r_t[2];
            r_c5  <= r_c4;
            r_bad <= r_det[smi_pkg::DET_W-1] || (r_det == '0);
            r_den <= {r_det[smi_pkg::DET_W-2:0], 1'b0};
            for (int k = 0; k < 6; k++) begin
                r_neg[k] <= r_c5[k][smi_pkg::CP_W-1];
                r_num[k] <= (smi_pkg::NUM_W'(c5_mag[k]) << (2 * smi_pkg::F + 1))
                            + smi_pkg::NUM_W'(r_det[smi_pkg::DET_W-2:0]);
            end
            r_out.bad <= r_bad;
            r_out.den <= r_den;
            for (int k = 0; k < 6; k++) begin
                r_out.lane[k].neg <= r_neg[k];
                r_out.lane[k].ovf <= smi_pkg::XW'(r_num[k][smi_pkg::NUM_W-1:smi_pkg::W])
                                     >= smi_pkg::XW'(r_den);
                r_out.lane[k].rem <= smi_pkg::DEN_W'(r_num[k][smi_pkg::NUM_W-1:smi_pkg::W]);
                r_out.lane[k].low <= r_num[k][smi_pkg::W-1:0];
                r_out.lane[k].q   <= '0;
            end
        end
    end

    assign o_cell = r_out;

endmodule
`default_nettype wire

FILE: rtl/smi_cell.sv
// One divider cell: develops one quotient bit for each of the six lanes.
// Depends on smi_pkg; chained in the top level.
`default_nettype none
module smi_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire smi_pkg::t_cell i_cell,
    output smi_pkg::t_cell      o_cell
);

    smi_pkg::t_cell r_cell;
    smi_pkg::t_cell n_cell;
    logic [smi_pkg::DEN_W:0] n_r2;

    always_comb begin
        n_r2   = '0;
        n_cell = i_cell;
        for (int k = 0; k < smi_pkg::LANES; k++) begin
            n_r2 = {i_cell.lane[k].rem, i_cell.lane[k].low[smi_pkg::W-1]};
            if (n_r2 >= {1'b0, i_cell.den}) begin
                n_r2 = n_r2 - {1'b0, i_cell.den};
                n_cell.lane[k].q = {i_cell.lane[k].q[smi_pkg::W-2:0], 1'b1};
            end else begin
                n_cell.lane[k].q = {i_cell.lane[k].q[smi_pkg::W-2:0], 1'b0};
            end
            n_cell.lane[k].rem = n_r2[smi_pkg::DEN_W-1:0];
            n_cell.lane[k].low = {i_cell.lane[k].low[smi_pkg::W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

FILE: rtl/sym3x3_matrix_inverse_unit.sv
// Top level of the symmetric 3x3 inverse unit: front pipeline, divider chain, output stage.
// Depends on smi_pkg, smi_front and smi_cell.
//
// One item is accepted in every cycle while o_stall is low, and each result
// passes through seven front stages for products, cofactors and the determinant,
// one divider cell per quotient bit (32 cells) and an output register. The
// whole pipeline advances together and holds only while a result is stalled.
`default_nettype none
module sym3x3_matrix_inverse_unit (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire smi_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire                    i_stall,
    output smi_pkg::t_out_item     o_result
);

    localparam logic [smi_pkg::W-1:0] NEG_LIM = {1'b1, {(smi_pkg::W-1){1'b0}}};
    localparam logic [smi_pkg::W-1:0] POS_LIM = {1'b0, {(smi_pkg::W-1){1'b1}}};

    logic                 en;
    smi_pkg::t_cell       chain [smi_pkg::W+1];
    logic                 r_valid;
    smi_pkg::t_out_item   r_res;
    smi_pkg::t_out_item   n_res;
    logic [smi_pkg::W-1:0] n_val [smi_pkg::LANES];
    logic [smi_pkg::LANES-1:0] n_sat;

    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    smi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_cell  (chain[0])
    );

    for (genvar g = 0; g < smi_pkg::W; g++) begin : g_cell
        smi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < smi_pkg::LANES; k++) begin
            if (chain[smi_pkg::W].lane[k].neg) begin
                n_sat[k] = chain[smi_pkg::W].lane[k].ovf
                           || (chain[smi_pkg::W].lane[k].q > NEG_LIM);
                n_val[k] = smi_pkg::W'(0) - (n_sat[k] ? NEG_LIM : chain[smi_pkg::W].lane[k].q);
            end else begin
                n_sat[k] = chain[smi_pkg::W].lane[k].ovf
                           || chain[smi_pkg::W].lane[k].q[smi_pkg::W-1];
                n_val[k] = n_sat[k] ? POS_LIM : chain[smi_pkg::W].lane[k].q;
            end
            if (chain[smi_pkg::W].bad) begin
                n_val[k] = '0;
                n_sat[k] = 1'b0;
            end
        end
        n_res.inv_xx          = n_val[0];
        n_res.inv_xy          = n_val[1];
        n_res.inv_xz          = n_val[2];
        n_res.inv_yy          = n_val[3];
        n_res.inv_yz          = n_val[4];
        n_res.inv_zz          = n_val[5];
        n_res.bad_determinant = chain[smi_pkg::W].bad;
        n_res.saturated       = |n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= chain[smi_pkg::W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.bad_determinant) |->
        (!o_result.saturated && o_result.inv_xx == '0 && o_result.inv_zz == '0))
        else $error("bad determinant item carries non-zero data");

    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output back-pressure");

    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(chain[smi_pkg::W].valid) && $stable(chain[0].valid))
        else $error("divider chain moved while held");

endmodule
`default_nettype wire
